/* rtl/core/csv_record_field_parser_defines.svh */
// Assertion macros for the CSV parser
`ifndef CSV_RECORD_FIELD_PARSER_DEFINES_SVH
`define CSV_RECORD_FIELD_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define CSV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csv parser check failed");

`define CSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csv parser check failed");

`else

`define CSV_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CSV_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/csv_rfp_pkg.sv */
`default_nettype none

package csv_rfp_pkg;

    localparam int unsigned MAX_FIELD_BYTES_DEF = 128;
    localparam int unsigned FIELD_COUNT_W       = 8;
    localparam int unsigned POS_W               = 7;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [1:0] PHASE_BLANK  = 2'd0;
    localparam logic [1:0] PHASE_DIGITS = 2'd1;
    localparam logic [1:0] PHASE_DONE   = 2'd2;

    localparam logic [2:0] COL_ID     = 3'd0;
    localparam logic [2:0] COL_LAST_S = 3'd3;
    localparam logic [2:0] COL_STATUS = 3'd4;
    localparam logic [2:0] COL_MAX    = 3'd7;

    localparam logic [2:0] STATUS_LEN = 3'd6;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    localparam logic [35:0] CAP_POS = 36'h0_7FFF_FFFF;
    localparam logic [35:0] CAP_NEG = 36'h0_8000_0000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic [1:0]         column;
        logic [7:0]         text_byte;
        logic [POS_W-1:0]   byte_position;
        logic signed [31:0] record_id;
        logic               active;
    } result_t;

    // letters of "active"
    function automatic logic [7:0] status_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'd97;
            3'd1:    c = 8'd99;
            3'd2:    c = 8'd116;
            3'd3:    c = 8'd105;
            3'd4:    c = 8'd118;
            3'd5:    c = 8'd101;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/csv_rfp_in_reg.sv */
`default_nettype none

module csv_rfp_in_reg (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  src_valid,
    output logic                       src_stall,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  end_of_input,
    input  wire logic                  out_free,
    output logic                       advance,
    output csv_rfp_pkg::in_item_t      item
);

    logic                  full_reg;
    logic                  full_next;
    csv_rfp_pkg::in_item_t item_reg;
    logic                  take;

    assign advance   = full_reg && out_free;
    assign src_stall = full_reg && !advance;
    assign take      = src_valid && !src_stall;
    assign item      = item_reg;

    always_comb
    begin
        if (take)
            full_next = 1'b1;
        else if (advance)
            full_next = 1'b0;
        else
            full_next = full_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.data_byte    <= data_byte;
            item_reg.end_of_input <= end_of_input;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/csv_rfp_parse.sv */
`default_nettype none

module csv_rfp_parse #(
    parameter int unsigned MAX_FIELD_BYTES = csv_rfp_pkg::MAX_FIELD_BYTES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  wire csv_rfp_pkg::in_item_t item,
    output logic                       has_result,
    output csv_rfp_pkg::result_t       result
);

    localparam logic [csv_rfp_pkg::FIELD_COUNT_W-1:0] FIELD_LIMIT =
        csv_rfp_pkg::FIELD_COUNT_W'(MAX_FIELD_BYTES);

    logic [2:0]  column_reg,   column_next;
    logic [1:0]  phase_reg,    phase_next;
    logic        neg_reg,      neg_next;
    logic [31:0] value_reg,    value_next;
    logic [2:0]  match_reg,    match_next;
    logic        mismatch_reg, mismatch_next;
    logic        active_reg,   active_next;
    logic [csv_rfp_pkg::FIELD_COUNT_W-1:0] count_reg, count_next;

    logic [7:0]  b;
    logic        is_end;
    logic        is_comma;
    logic        digit;
    logic        blank;
    logic        closed_active;
    logic [35:0] scaled;
    logic [35:0] cap;
    logic [31:0] value_acc;

    assign b        = item.data_byte;
    assign is_end   = item.end_of_input || (b == csv_rfp_pkg::CH_LF)
                      || (b == csv_rfp_pkg::CH_NUL);
    assign is_comma = (b == csv_rfp_pkg::CH_COMMA);
    assign digit    = (b >= csv_rfp_pkg::CH_ZERO) && (b <= csv_rfp_pkg::CH_NINE);
    assign blank    = (b == csv_rfp_pkg::CH_SPACE) || (b == csv_rfp_pkg::CH_TAB)
                      || (b == csv_rfp_pkg::CH_VT) || (b == csv_rfp_pkg::CH_FF)
                      || (b == csv_rfp_pkg::CH_CR);

    // status field result as it stands if the field closes now
    assign closed_active = (column_reg == csv_rfp_pkg::COL_STATUS)
                           ? (!mismatch_reg && (match_reg == csv_rfp_pkg::STATUS_LEN))
                           : active_reg;

    // value * 10 + digit, saturated to the signed limit
    assign scaled = ({4'd0, value_reg} << 3) + ({4'd0, value_reg} << 1)
                    + {28'd0, b - csv_rfp_pkg::CH_ZERO};
    assign cap    = neg_reg ? csv_rfp_pkg::CAP_NEG : csv_rfp_pkg::CAP_POS;
    assign value_acc = (scaled > cap) ? cap[31:0] : scaled[31:0];

    always_comb
    begin
        column_next   = column_reg;
        phase_next    = phase_reg;
        neg_next      = neg_reg;
        value_next    = value_reg;
        match_next    = match_reg;
        mismatch_next = mismatch_reg;
        active_next   = active_reg;
        count_next    = count_reg;
        has_result    = 1'b0;

        result.kind          = csv_rfp_pkg::KIND_BYTE;
        result.column        = 2'd0;
        result.text_byte     = 8'd0;
        result.byte_position = '0;
        result.record_id     = 32'sd0;
        result.active        = 1'b0;

        if (is_end)
        begin
            has_result       = 1'b1;
            result.kind      = csv_rfp_pkg::KIND_RECORD;
            result.record_id = neg_reg ? -value_reg : value_reg;
            result.active    = closed_active;
            column_next      = csv_rfp_pkg::COL_ID;
            phase_next       = csv_rfp_pkg::PHASE_BLANK;
            neg_next         = 1'b0;
            value_next       = 32'd0;
            active_next      = 1'b0;
            match_next       = 3'd0;
            mismatch_next    = 1'b0;
            count_next       = '0;
        end
        else if (is_comma)
        begin
            active_next   = closed_active;
            if (column_reg != csv_rfp_pkg::COL_MAX)
                column_next = column_reg + 3'd1;
            match_next    = 3'd0;
            mismatch_next = 1'b0;
            count_next    = '0;
        end
        else if (column_reg == csv_rfp_pkg::COL_ID)
        begin
            case (phase_reg)
                csv_rfp_pkg::PHASE_BLANK:
                begin
                    if (b == csv_rfp_pkg::CH_MINUS || b == csv_rfp_pkg::CH_PLUS)
                    begin
                        neg_next   = (b == csv_rfp_pkg::CH_MINUS);
                        phase_next = csv_rfp_pkg::PHASE_DIGITS;
                    end
                    else if (digit)
                    begin
                        phase_next = csv_rfp_pkg::PHASE_DIGITS;
                        value_next = value_acc;
                    end
                    else if (!blank)
                        phase_next = csv_rfp_pkg::PHASE_DONE;
                end
                csv_rfp_pkg::PHASE_DIGITS:
                begin
                    if (digit)
                        value_next = value_acc;
                    else
                        phase_next = csv_rfp_pkg::PHASE_DONE;
                end
                default:
                begin
                end
            endcase
        end
        else if (column_reg <= csv_rfp_pkg::COL_LAST_S)
        begin
            if (count_reg < FIELD_LIMIT)
            begin
                has_result           = 1'b1;
                result.column        = column_reg[1:0];
                result.text_byte     = b;
                result.byte_position = count_reg[csv_rfp_pkg::POS_W-1:0];
                count_next           = count_reg + 1'b1;
            end
        end
        else if (column_reg == csv_rfp_pkg::COL_STATUS)
        begin
            if (match_reg < csv_rfp_pkg::STATUS_LEN
                && b == csv_rfp_pkg::status_char(match_reg))
                match_next = match_reg + 3'd1;
            else
                mismatch_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg   <= csv_rfp_pkg::COL_ID;
            phase_reg    <= csv_rfp_pkg::PHASE_BLANK;
            neg_reg      <= 1'b0;
            value_reg    <= 32'd0;
            match_reg    <= 3'd0;
            mismatch_reg <= 1'b0;
            active_reg   <= 1'b0;
            count_reg    <= '0;
        end
        else if (advance)
        begin
            column_reg   <= column_next;
            phase_reg    <= phase_next;
            neg_reg      <= neg_next;
            value_reg    <= value_next;
            match_reg    <= match_next;
            mismatch_reg <= mismatch_next;
            active_reg   <= active_next;
            count_reg    <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/csv_rfp_out_reg.sv */
`default_nettype none

module csv_rfp_out_reg (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire csv_rfp_pkg::result_t  result,
    output logic                       out_free,
    output logic                       res_valid,
    input  wire logic                  res_stall,
    output csv_rfp_pkg::result_t       res
);

    logic                 valid_reg;
    logic                 valid_next;
    csv_rfp_pkg::result_t res_reg;

    assign out_free  = !valid_reg || !res_stall;
    assign res_valid = valid_reg;
    assign res       = res_reg;

    // held request stays unless taken; load only when free
    assign valid_next = (valid_reg && res_stall) || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= result;
    end

endmodule

`default_nettype wire

/* rtl/core/csv_record_field_parser.sv */
// A byte accepted into the input register passes the parse stage into the result register, which drives res_valid.
// Throughput: one byte per cycle while res_stall does not hold a full result register; then the source is stalled.
// A byte that yields nothing still takes one pass through the parse stage.
// Reset (rst_n low, asynchronous) empties both registers and clears all record state.
`default_nettype none

`include "csv_record_field_parser_defines.svh"

module csv_record_field_parser #(
    parameter int unsigned MAX_FIELD_BYTES = csv_rfp_pkg::MAX_FIELD_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        src_valid,
    output logic             src_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_input,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic             kind,
    output logic [1:0]       column,
    output logic [7:0]       text_byte,
    output logic [6:0]       byte_position,
    output logic signed [31:0] record_id,
    output logic             active
);

    logic                  out_free;
    logic                  advance;
    logic                  has_result;
    csv_rfp_pkg::in_item_t item;
    csv_rfp_pkg::result_t  result;
    csv_rfp_pkg::result_t  res;

    csv_rfp_in_reg u_in (
        .clk          (clk),
        .rst_n        (rst_n),
        .src_valid    (src_valid),
        .src_stall    (src_stall),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .out_free     (out_free),
        .advance      (advance),
        .item         (item)
    );

    csv_rfp_parse #(
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item       (item),
        .has_result (has_result),
        .result     (result)
    );

    csv_rfp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && has_result),
        .result    (result),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    assign kind          = res.kind;
    assign column        = res.column;
    assign text_byte     = res.text_byte;
    assign byte_position = res.byte_position;
    assign record_id     = res.record_id;
    assign active        = res.active;

    `CSV_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, src_stall, res_valid && res_stall)
    `CSV_ASSERT_NEXT(a_stalled_byte_kept, clk, rst_n, src_stall && src_valid, src_stall || advance)
    `CSV_ASSERT_NOW(a_record_fields, clk, rst_n, res_valid && kind,
        column == 2'd0 && text_byte == 8'd0 && byte_position == 7'd0)
    `CSV_ASSERT_NOW(a_byte_fields, clk, rst_n, res_valid && !kind,
        column != 2'd0 && record_id == 32'sd0 && !active)

endmodule

`default_nettype wire
